>>> rtl/sra_pkg.sv
// Shared types and constants of the two-bit slot run allocator.
// Used by sra_engine and two_bit_slot_run_allocator; no dependencies.
`default_nettype none

package sra_pkg;

    // Field widths of the request and the result
    localparam int RUN_W   = 11;   // run_length
    localparam int IDX_W   = 10;   // slot_index, start_slot
    localparam int CNT_W   = 11;   // freed_count, slots_in_use
    localparam int OUTC_W  = 2;    // outcome
    localparam int TDATA_W = 24;   // packed payload, padded to whole bytes
    localparam int SLOT_W  = 2;    // status code per slot

    // Slots managed after reset
    localparam logic [CNT_W-1:0] SLOTS_RESET = 11'd1024;

    // Request operation
    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    // Slot status codes
    localparam logic [SLOT_W-1:0] ST_FREE   = 2'd0;
    localparam logic [SLOT_W-1:0] ST_SINGLE = 2'd1;
    localparam logic [SLOT_W-1:0] ST_START  = 2'd2;
    localparam logic [SLOT_W-1:0] ST_END    = 2'd3;

    typedef enum logic [OUTC_W-1:0] {
        OC_ALLOC   = 2'd0,
        OC_NOROOM  = 2'd1,
        OC_FREED   = 2'd2,
        OC_ILLEGAL = 2'd3
    } t_outcome;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_FIND,
        S_WALK,
        S_MARK,
        S_DONE
    } t_state;

    typedef struct packed {
        t_outcome             outcome;
        logic [IDX_W-1:0]     start_slot;
        logic [CNT_W-1:0]     freed_count;
    } t_result;

endpackage

`default_nettype wire

>>> rtl/two_bit_slot_run_allocator.sv
// Top level of the two-bit slot run allocator: slots_in_use register,
// result output register and the sequencer. Depends on sra_pkg, sra_engine.
`default_nettype none

// Usage
//   Requests enter on the s_axis channel, one result per request leaves on
//   m_axis. tuser carries the operation (0 allocate, 1 free) in and the outcome
//   (0 allocated, 1 no room, 2 freed, 3 illegal free) out.
//   i_cfg_we/i_cfg_wdata set slots_in_use; write only while the block is idle.
//   Values above MAX_SLOTS act as MAX_SLOTS.
// Sequence (L = slots in use)
//   One request at a time; status lives in one RAM with a registered read.
//   Allocate: first-fit scan of slots 0 to L-1, one write per slot if a run fits.
//   Free: a read of the slot (clears a single slot), a walk to the end code and
//   one write per freed slot for a run. A rejected request (zero length, too
//   long, out of range) posts at once. The next request is taken after the post.
// Reset
//   After reset a clearing pass writes every status entry to free, one per
//   cycle; s_axis_tready stays low during the pass.
// Stalls
//   The result register holds while m_axis_tready is low; the next request is
//   still taken and worked on, and waits at its end until the register frees.

module two_bit_slot_run_allocator #(
    parameter int MAX_SLOTS = 1024
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // configuration: slots_in_use
    input  wire logic                          i_cfg_we,
    input  wire logic [sra_pkg::CNT_W-1:0]     i_cfg_wdata,
    // request channel
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [sra_pkg::TDATA_W-1:0]   s_axis_tdata,  // run_length[10:0], slot_index[20:11]
    input  wire logic                          s_axis_tuser,  // func
    // result channel
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic      [sra_pkg::TDATA_W-1:0]   m_axis_tdata,  // start_slot[9:0], freed_count[20:10]
    output logic      [sra_pkg::OUTC_W-1:0]    m_axis_tuser   // outcome
);
    import sra_pkg::*;

    // Counter width: must hold MAX_SLOTS itself and every 11-bit field
    localparam int CW = ($clog2(MAX_SLOTS + 1) > CNT_W) ? $clog2(MAX_SLOTS + 1) : CNT_W;
    localparam logic [CW-1:0] MAX_W   = CW'(MAX_SLOTS);
    localparam logic [CW-1:0] RST_LIM = (CW'(SLOTS_RESET) > MAX_W) ? MAX_W
                                                                   : CW'(SLOTS_RESET);
    localparam int PAD_W = TDATA_W - IDX_W - CNT_W;

    logic [CW-1:0] r_lim, n_lim;
    logic [CW-1:0] cfg_w;
    logic          r_out_vld, n_out_vld;
    t_result       r_res;
    t_result       eng_res;
    logic          eng_res_valid, eng_res_ready;

    // Hold the clamped slot count so the sequencer never sees values past the RAM
    assign cfg_w = CW'(i_cfg_wdata);

    always_comb begin
        n_lim = r_lim;
        if (i_cfg_we) begin
            n_lim = (cfg_w > MAX_W) ? MAX_W : cfg_w;
        end
    end

    sra_engine #(
        .MAX_SLOTS (MAX_SLOTS),
        .CW        (CW)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_lim       (r_lim),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_func      (s_axis_tuser),
        .i_want      (s_axis_tdata[RUN_W-1:0]),
        .i_at        (s_axis_tdata[RUN_W+IDX_W-1:RUN_W]),
        .o_res_valid (eng_res_valid),
        .i_res_ready (eng_res_ready),
        .o_res       (eng_res)
    );

    // Output register: load when empty or being drained this cycle
    assign eng_res_ready = !r_out_vld || m_axis_tready;

    always_comb begin
        n_out_vld = r_out_vld;
        if (eng_res_valid && eng_res_ready) begin
            n_out_vld = 1'b1;
        end else if (m_axis_tready) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lim     <= RST_LIM;
            r_out_vld <= 1'b0;
        end else begin
            r_lim     <= n_lim;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (eng_res_valid && eng_res_ready) begin
            r_res <= eng_res;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, r_res.freed_count, r_res.start_slot};
    assign m_axis_tuser  = r_res.outcome;

endmodule

`default_nettype wire

>>> rtl/sra_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module sra_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> rtl/sra_engine.sv
// Sequencer of the slot run allocator: clearing pass, first-fit scan, run walk
// and mark/clear writes over the slot status RAM. Depends on sra_pkg, sra_ram.
`default_nettype none

module sra_engine #(
    parameter int MAX_SLOTS = 1024,
    parameter int CW        = 11
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic [CW-1:0]               i_lim,
    input  wire logic                        i_valid,
    output logic                             o_ready,
    input  wire logic                        i_func,
    input  wire logic [sra_pkg::RUN_W-1:0]   i_want,
    input  wire logic [sra_pkg::IDX_W-1:0]   i_at,
    output logic                             o_res_valid,
    input  wire logic                        i_res_ready,
    output sra_pkg::t_result                 o_res
);
    import sra_pkg::*;

    localparam int AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_SLOTS - 1);

    t_state          r_state, n_state;
    logic            r_op, n_op;
    logic [CW-1:0]   r_want, n_want;
    logic [CW-1:0]   r_rd_addr, n_rd_addr;
    logic            r_pend, n_pend;
    logic [CW-1:0]   r_chk_idx, n_chk_idx;
    logic [CW-1:0]   r_run, n_run;
    logic [CW-1:0]   r_first, n_first;
    logic [CW-1:0]   r_last, n_last;
    logic [CW-1:0]   r_wr_addr, n_wr_addr;
    t_outcome        r_outcome, n_outcome;

    logic              ram_we, ram_re;
    logic [AW-1:0]     ram_waddr, ram_raddr;
    logic [SLOT_W-1:0] ram_wdata, ram_rdata;
    logic [CW-1:0]     want_w, at_w, run_inc, span;
    logic              issue;

    sra_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (MAX_SLOTS)
    ) u_status (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign want_w  = CW'(i_want);
    assign at_w    = CW'(i_at);
    assign run_inc = r_run + CW'(1);
    assign issue   = (r_rd_addr < i_lim);
    assign span    = r_last - r_first + CW'(1);

    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_want    = r_want;
        n_rd_addr = r_rd_addr;
        n_pend    = r_pend;
        n_chk_idx = r_chk_idx;
        n_run     = r_run;
        n_first   = r_first;
        n_last    = r_last;
        n_wr_addr = r_wr_addr;
        n_outcome = r_outcome;
        ram_we    = 1'b0;
        ram_waddr = r_wr_addr[AW-1:0];
        ram_wdata = ST_FREE;
        ram_re    = 1'b0;
        ram_raddr = r_rd_addr[AW-1:0];
        o_ready   = 1'b0;
        o_res_valid = 1'b0;

        unique case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                n_wr_addr = r_wr_addr + CW'(1);
                if (r_wr_addr[AW-1:0] == LAST_ADDR) begin
                    n_state = S_IDLE;
                end
            end

            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_op      = i_func;
                    n_want    = want_w;
                    n_run     = '0;
                    n_pend    = 1'b0;
                    n_rd_addr = '0;
                    n_first   = at_w;
                    n_last    = at_w;
                    if (i_func == FUNC_ALLOC) begin
                        if (want_w == '0 || want_w > i_lim) begin
                            n_outcome = OC_NOROOM;
                            n_state   = S_DONE;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end else begin
                        if (at_w >= i_lim) begin
                            n_outcome = OC_ILLEGAL;
                            n_state   = S_DONE;
                        end else begin
                            ram_re    = 1'b1;
                            ram_raddr = at_w[AW-1:0];
                            n_state   = S_FIND;
                        end
                    end
                end
            end

            S_SCAN: begin
                // One read issued and one status checked per cycle
                if (r_pend && ram_rdata == ST_FREE && run_inc == r_want) begin
                    n_first   = r_chk_idx + CW'(1) - r_want;
                    n_last    = r_chk_idx;
                    n_wr_addr = r_chk_idx + CW'(1) - r_want;
                    n_pend    = 1'b0;
                    n_state   = S_MARK;
                end else begin
                    if (r_pend) begin
                        n_run = (ram_rdata == ST_FREE) ? run_inc : '0;
                    end
                    if (issue) begin
                        ram_re    = 1'b1;
                        n_rd_addr = r_rd_addr + CW'(1);
                        n_chk_idx = r_rd_addr;
                        n_pend    = 1'b1;
                    end else begin
                        n_pend = 1'b0;
                    end
                    if (!r_pend && !issue) begin
                        n_outcome = OC_NOROOM;
                        n_state   = S_DONE;
                    end
                end
            end

            S_FIND: begin
                case (ram_rdata)
                    ST_SINGLE: begin
                        ram_we    = 1'b1;
                        ram_waddr = r_first[AW-1:0];
                        n_outcome = OC_FREED;
                        n_state   = S_DONE;
                    end
                    ST_START: begin
                        n_rd_addr = r_first + CW'(1);
                        n_pend    = 1'b0;
                        n_state   = S_WALK;
                    end
                    default: begin
                        n_outcome = OC_ILLEGAL;
                        n_state   = S_DONE;
                    end
                endcase
            end

            S_WALK: begin
                // Look for the first end code after the run start
                if (r_pend && ram_rdata == ST_END) begin
                    n_last    = r_chk_idx;
                    n_wr_addr = r_first;
                    n_pend    = 1'b0;
                    n_state   = S_MARK;
                end else begin
                    if (issue) begin
                        ram_re    = 1'b1;
                        n_rd_addr = r_rd_addr + CW'(1);
                        n_chk_idx = r_rd_addr;
                        n_pend    = 1'b1;
                    end else begin
                        n_pend = 1'b0;
                    end
                    if (!r_pend && !issue) begin
                        n_outcome = OC_ILLEGAL;
                        n_state   = S_DONE;
                    end
                end
            end

            S_MARK: begin
                ram_we    = 1'b1;
                n_wr_addr = r_wr_addr + CW'(1);
                if (r_op == FUNC_FREE) begin
                    ram_wdata = ST_FREE;
                end else if (r_first == r_last) begin
                    ram_wdata = ST_SINGLE;
                end else if (r_wr_addr == r_first) begin
                    ram_wdata = ST_START;
                end else if (r_wr_addr == r_last) begin
                    ram_wdata = ST_END;
                end else begin
                    ram_wdata = ST_SINGLE;
                end
                if (r_wr_addr == r_last) begin
                    n_outcome = (r_op == FUNC_FREE) ? OC_FREED : OC_ALLOC;
                    n_state   = S_DONE;
                end
            end

            S_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_res.outcome     = r_outcome;
        o_res.start_slot  = (r_outcome == OC_ALLOC) ? r_first[IDX_W-1:0] : '0;
        o_res.freed_count = (r_outcome == OC_FREED) ? span[CNT_W-1:0] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_wr_addr <= '0;
            r_pend    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_wr_addr <= n_wr_addr;
            r_pend    <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_want    <= n_want;
        r_rd_addr <= n_rd_addr;
        r_chk_idx <= n_chk_idx;
        r_run     <= n_run;
        r_first   <= n_first;
        r_last    <= n_last;
        r_outcome <= n_outcome;
    end

endmodule

`default_nettype wire
